// ----- src/switch_command_retry_sender_assert.svh -----
// switch_command_retry_sender_assert.svh: assertion macros for the retry sender
// expects signals named clk and rst_n in the scope where a macro is used
`ifndef SWITCH_COMMAND_RETRY_SENDER_ASSERT_SVH
`define SWITCH_COMMAND_RETRY_SENDER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define SCRS_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("scrs assertion failed");

// next-cycle implication, checked out of reset
`define SCRS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("scrs assertion failed");

`else

`define SCRS_ASSERT_NOW(lbl, pre, post)
`define SCRS_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

// ----- src/scrs_pkg.sv -----
// scrs_pkg: types and constants of the switch command retry sender
// no dependencies
`default_nettype none

package scrs_pkg;

  // protocol phases
  typedef enum logic [1:0] {
    PH_IDLE         = 2'd0,
    PH_SEND         = 2'd1,
    PH_WAIT_ACK     = 2'd2,
    PH_WAIT_RELEASE = 2'd3
  } phase_t;

  // configuration register indexes
  localparam logic [1:0] REG_RETRY_LIMIT       = 2'd0;
  localparam logic [1:0] REG_ACK_TIMEOUT       = 2'd1;
  localparam logic [1:0] REG_HOLD_TIME         = 2'd2;
  localparam logic [1:0] REG_RELEASE_THRESHOLD = 2'd3;

  // reset values of the configuration registers
  localparam logic [3:0]  RST_RETRY_LIMIT       = 4'd5;
  localparam logic [15:0] RST_ACK_TIMEOUT       = 16'd50;
  localparam logic [15:0] RST_HOLD_TIME         = 16'd2000;
  localparam logic [15:0] RST_RELEASE_THRESHOLD = 16'd1800;

  // color codes
  localparam logic [2:0] COLOR_RED   = 3'd0;
  localparam logic [2:0] COLOR_GREEN = 3'd1;
  localparam logic [2:0] COLOR_BLUE  = 3'd2;
  localparam logic [2:0] COLOR_WARM  = 3'd3;
  localparam logic [2:0] COLOR_COLD  = 3'd4;

  typedef struct packed {
    logic [3:0]  retry_limit;
    logic [15:0] ack_timeout;
    logic [15:0] hold_time;
    logic [15:0] release_threshold;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  color;
    logic [3:0]  attempts;
    logic [15:0] timer;
  } state_t;

endpackage

`default_nettype wire

// ----- src/scrs_cfg.sv -----
// scrs_cfg: configuration register file of the retry sender
// depends on scrs_pkg
`default_nettype none

module scrs_cfg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [15:0]   cfg_wdata,
  output scrs_pkg::cfg_t     cfg
);

  scrs_pkg::cfg_t cfg_r;
  scrs_pkg::cfg_t cfg_nxt;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        scrs_pkg::REG_RETRY_LIMIT:       cfg_nxt.retry_limit       = cfg_wdata[3:0];
        scrs_pkg::REG_ACK_TIMEOUT:       cfg_nxt.ack_timeout       = cfg_wdata;
        scrs_pkg::REG_HOLD_TIME:         cfg_nxt.hold_time         = cfg_wdata;
        scrs_pkg::REG_RELEASE_THRESHOLD: cfg_nxt.release_threshold = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.retry_limit       <= scrs_pkg::RST_RETRY_LIMIT;
      cfg_r.ack_timeout       <= scrs_pkg::RST_ACK_TIMEOUT;
      cfg_r.hold_time         <= scrs_pkg::RST_HOLD_TIME;
      cfg_r.release_threshold <= scrs_pkg::RST_RELEASE_THRESHOLD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- src/scrs_step.sv -----
// scrs_step: one pass of the send/ack/retry rule, purely combinational
// depends on scrs_pkg
`default_nettype none

module scrs_step (
  input  wire scrs_pkg::state_t st,
  input  wire scrs_pkg::cfg_t   cfg,
  input  wire logic [4:0]    switch_levels,
  input  wire logic          ack_ok,
  input  wire logic          ack_nok,
  input  wire logic          tick,
  output scrs_pkg::state_t   st_nxt,
  output logic               send_strobe
);

  logic [15:0]   timer_dec;
  logic          timer_zero;
  logic          any_sw;
  logic [2:0]    pick;
  logic          have_attempts;
  scrs_pkg::phase_t phase_nxt;

  // tick decrements the standby timer, saturating at zero
  assign timer_dec     = (tick && (st.timer != 16'd0)) ? st.timer - 16'd1 : st.timer;
  assign timer_zero    = (timer_dec == 16'd0);
  assign any_sw        = |switch_levels;
  assign have_attempts = (st.attempts != 4'd0);

  // color priority: cold, warm, blue, green, red
  always_comb begin
    if (switch_levels[4])      pick = scrs_pkg::COLOR_COLD;
    else if (switch_levels[3]) pick = scrs_pkg::COLOR_WARM;
    else if (switch_levels[2]) pick = scrs_pkg::COLOR_BLUE;
    else if (switch_levels[1]) pick = scrs_pkg::COLOR_GREEN;
    else                       pick = scrs_pkg::COLOR_RED;
  end

  // next phase
  always_comb begin
    phase_nxt = st.phase;
    unique case (st.phase)
      scrs_pkg::PH_IDLE: begin
        if (any_sw) phase_nxt = scrs_pkg::PH_SEND;
      end
      scrs_pkg::PH_SEND: begin
        phase_nxt = have_attempts ? scrs_pkg::PH_WAIT_ACK : scrs_pkg::PH_IDLE;
      end
      scrs_pkg::PH_WAIT_ACK: begin
        // reject wins over a simultaneous acknowledge
        if (ack_nok || (!ack_ok && timer_zero)) phase_nxt = scrs_pkg::PH_SEND;
        else if (ack_ok && cfg.hold_time == 16'd0) phase_nxt = scrs_pkg::PH_SEND;
        else if (ack_ok) phase_nxt = scrs_pkg::PH_WAIT_RELEASE;
      end
      scrs_pkg::PH_WAIT_RELEASE: begin
        if (timer_zero || (!any_sw && timer_dec < cfg.release_threshold))
          phase_nxt = scrs_pkg::PH_IDLE;
      end
      default: phase_nxt = scrs_pkg::PH_IDLE;
    endcase
  end

  // data path and strobe
  always_comb begin
    st_nxt.phase    = phase_nxt;
    st_nxt.color    = st.color;
    st_nxt.attempts = st.attempts;
    st_nxt.timer    = timer_dec;
    send_strobe     = 1'b0;
    unique case (st.phase)
      scrs_pkg::PH_IDLE: begin
        if (any_sw) begin
          st_nxt.color    = pick;
          st_nxt.attempts = cfg.retry_limit;
        end
      end
      scrs_pkg::PH_SEND: begin
        if (have_attempts) begin
          st_nxt.attempts = st.attempts - 4'd1;
          st_nxt.timer    = cfg.ack_timeout;
          send_strobe     = 1'b1;
        end
      end
      scrs_pkg::PH_WAIT_ACK: begin
        if (ack_ok) st_nxt.timer = cfg.hold_time;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/switch_command_retry_sender.sv -----
// switch_command_retry_sender: top level of the stop-and-wait color command sender
// depends on scrs_pkg, scrs_cfg, scrs_step and switch_command_retry_sender_assert.svh
//
// Usage:
//   Input channel (in_valid/in_stall): one item per control-loop pass, holding
//   the five switch levels, the ack/nak flags and the millisecond tick.
//   Result channel (out_valid/out_stall): exactly one result item per input
//   item, in order: send strobe, held color code, phase and retries left.
//   Configuration: cfg_we writes cfg_wdata into register cfg_index (0 retry
//   limit, 1 ack timeout, 2 hold time, 3 release threshold); write only when
//   no item is in flight.
//   Flow: an accepted item waits in the input register, then passes the step
//   rule into the result register once that is free. Throughput: one item
//   per cycle while out_stall is low; the step rule between the input register
//   and the result register is purely combinational, and the protocol state
//   updates as each item moves into the result register.
//   Stall: while out_stall holds a full result register, the input register
//   keeps its item and in_stall is raised; nothing is dropped.
//   Reset (rst_n low, synchronous): both registers empty, phase idle, color,
//   attempts and timer zero, configuration back to 5/50/2000/1800.
`default_nettype none

module switch_command_retry_sender (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input channel
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [4:0]   in_switch_levels,
  input  wire logic         in_ack_ok,
  input  wire logic         in_ack_nok,
  input  wire logic         in_tick,
  // result channel
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic              out_send_strobe,
  output logic [2:0]        out_color_code,
  output logic [1:0]        out_phase,
  output logic [3:0]        out_retries_left,
  // configuration port
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [15:0]  cfg_wdata
);

`include "switch_command_retry_sender_assert.svh"

  scrs_pkg::cfg_t   cfg;
  scrs_pkg::state_t st_r;
  scrs_pkg::state_t st_nxt;
  logic             strobe_nxt;

  logic             in_v_r;
  logic [4:0]       sw_r;
  logic             ok_r;
  logic             nok_r;
  logic             tick_r;

  logic             out_v_r;
  logic             strobe_r;
  logic [2:0]       color_r;
  logic [1:0]       phase_r;
  logic [3:0]       retries_r;

  logic             fire;

  // configuration registers
  scrs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // step rule on the registered item
  scrs_step u_step (
    .st            (st_r),
    .cfg           (cfg),
    .switch_levels (sw_r),
    .ack_ok        (ok_r),
    .ack_nok       (nok_r),
    .tick          (tick_r),
    .st_nxt        (st_nxt),
    .send_strobe   (strobe_nxt)
  );

  // handshake: input register moves on when the result register is free
  assign fire     = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      sw_r   <= in_switch_levels;
      ok_r   <= in_ack_ok;
      nok_r  <= in_ack_nok;
      tick_r <= in_tick;
    end
  end

  // protocol state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase    <= scrs_pkg::PH_IDLE;
      st_r.color    <= 3'd0;
      st_r.attempts <= 4'd0;
      st_r.timer    <= 16'd0;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      strobe_r  <= strobe_nxt;
      color_r   <= st_nxt.color;
      phase_r   <= st_nxt.phase;
      retries_r <= st_nxt.attempts;
    end
  end

  assign out_valid        = out_v_r;
  assign out_send_strobe  = strobe_r;
  assign out_color_code   = color_r;
  assign out_phase        = phase_r;
  assign out_retries_left = retries_r;

  // a strobe always leaves the block waiting for an acknowledge
  `SCRS_ASSERT_NOW(a_strobe_wait_ack, out_v_r && strobe_r, phase_r == scrs_pkg::PH_WAIT_ACK)
  // the input side only stalls behind a full, stalled result register
  `SCRS_ASSERT_NOW(a_stall_cause, in_stall, out_v_r && out_stall)
  // a send with attempts left uses one up
  `SCRS_ASSERT_NEXT(a_attempt_used,
    fire && st_r.phase == scrs_pkg::PH_SEND && st_r.attempts != 4'd0,
    st_r.attempts == $past(st_r.attempts) - 4'd1)

endmodule

`default_nettype wire

// ----- bench/tb_switch_command_retry_sender.sv -----
// tb_switch_command_retry_sender: self-checking bench for the switch command retry sender
// needs scrs_pkg and the switch_command_retry_sender rtl; predicts each result item and
// compares it field by field under several settings and idle and stall patterns

module tb_switch_command_retry_sender;

  // cycles with no handshake at all before the run is declared hung
  localparam int QUIET_LIMIT = 2000;
  localparam int PASSES_PER_PHASE = 165;
  localparam int RANDOM_PHASES = 8;
  localparam int HOLD_OFF_CYCLES = 80;

  // one expected result item
  typedef struct packed {
    logic       strobe;
    logic [2:0] color;
    scrs_pkg::phase_t phase;
    logic [3:0] retries;
  } command_t;

  // tracks the sender state and holds the commands still to come out
  class retry_sender_scoreboard;
    scrs_pkg::cfg_t   settings;
    scrs_pkg::phase_t fsm;
    logic [2:0] color;
    logic [3:0] attempts;
    logic [15:0] standby;
    command_t   pending[$];
    int         errors;
    int         checked;
    int         strobes;
    int         accepted;

    function new();
      settings = '{scrs_pkg::RST_RETRY_LIMIT, scrs_pkg::RST_ACK_TIMEOUT,
                   scrs_pkg::RST_HOLD_TIME, scrs_pkg::RST_RELEASE_THRESHOLD};
      fsm = scrs_pkg::PH_IDLE;
      color = scrs_pkg::COLOR_RED;
      attempts = '0;
      standby = '0;
      errors = 0;
      checked = 0;
      strobes = 0;
      accepted = 0;
    endfunction

    // one accepted control-loop pass
    function void note_pass(logic [4:0] sw, logic ok, logic nok, logic tick);
      command_t cmd;
      cmd.strobe = 1'b0;
      if (tick && standby != 0) standby--;
      case (fsm)
        scrs_pkg::PH_IDLE: begin
          if (sw != 0) begin
            // cold wins, red only when nothing else is pressed
            if (sw[4]) color = scrs_pkg::COLOR_COLD;
            else if (sw[3]) color = scrs_pkg::COLOR_WARM;
            else if (sw[2]) color = scrs_pkg::COLOR_BLUE;
            else if (sw[1]) color = scrs_pkg::COLOR_GREEN;
            else color = scrs_pkg::COLOR_RED;
            attempts = settings.retry_limit;
            fsm = scrs_pkg::PH_SEND;
          end
        end
        scrs_pkg::PH_SEND: begin
          if (attempts != 0) begin
            attempts--;
            standby = settings.ack_timeout;
            cmd.strobe = 1'b1;
            fsm = scrs_pkg::PH_WAIT_ACK;
          end else begin
            fsm = scrs_pkg::PH_IDLE;
          end
        end
        scrs_pkg::PH_WAIT_ACK: begin
          // ack reloads the timer even when a nak overrides the phase
          if (ok) begin
            fsm = scrs_pkg::PH_WAIT_RELEASE;
            standby = settings.hold_time;
          end
          if (nok || standby == 0) fsm = scrs_pkg::PH_SEND;
        end
        default: begin
          if (standby == 0) fsm = scrs_pkg::PH_IDLE;
          if (sw == 0 && standby < settings.release_threshold) fsm = scrs_pkg::PH_IDLE;
        end
      endcase
      cmd.color = color;
      cmd.phase = fsm;
      cmd.retries = attempts;
      pending.push_back(cmd);
      accepted++;
    endfunction

    // one accepted result item against the oldest expectation
    function void check_command(logic strobe, logic [2:0] col, logic [1:0] ph,
                                logic [3:0] left);
      command_t want;
      if (pending.size() == 0) begin
        $error("unexpected result: send_strobe %0d color_code %0d phase %0d retries_left %0d",
               strobe, col, ph, left);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (strobe === 1'b1) strobes++;
      if (strobe !== want.strobe) begin
        $error("send_strobe: expected %0d, actual %0d", want.strobe, strobe);
        errors++;
      end
      if (col !== want.color) begin
        $error("color_code: expected %0d, actual %0d", want.color, col);
        errors++;
      end
      if (ph !== want.phase) begin
        $error("phase: expected %0d, actual %0d", want.phase, ph);
        errors++;
      end
      if (left !== want.retries) begin
        $error("retries_left: expected %0d, actual %0d", want.retries, left);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [4:0]  in_switch_levels;
  logic        in_ack_ok;
  logic        in_ack_nok;
  logic        in_tick;
  logic        out_valid;
  logic        out_stall;
  logic        out_send_strobe;
  logic [2:0]  out_color_code;
  logic [1:0]  out_phase;
  logic [3:0]  out_retries_left;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  retry_sender_scoreboard sb;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int settings_applied = 0;

  switch_command_retry_sender uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_switch_levels (in_switch_levels),
    .in_ack_ok        (in_ack_ok),
    .in_ack_nok       (in_ack_nok),
    .in_tick          (in_tick),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_send_strobe  (out_send_strobe),
    .out_color_code   (out_color_code),
    .out_phase        (out_phase),
    .out_retries_left (out_retries_left),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #5 clk = ~clk;

  // offer one item, with random idle cycles ahead of it, and wait until it is taken
  task automatic offer_pass(input logic [4:0] sw, input logic ok, input logic nok,
                            input logic tick);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_switch_levels <= sw;
    in_ack_ok <= ok;
    in_ack_nok <= nok;
    in_tick <= tick;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_pass(sw, ok, nok, tick);
  endtask

  // stop offering, wait for every pending result, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // write all four registers back to back; only called with nothing in flight
  task automatic apply_settings(input scrs_pkg::cfg_t s);
    cfg_we <= 1'b1;
    cfg_index <= scrs_pkg::REG_RETRY_LIMIT;
    cfg_wdata <= 16'(s.retry_limit);
    @(posedge clk);
    cfg_index <= scrs_pkg::REG_ACK_TIMEOUT;
    cfg_wdata <= s.ack_timeout;
    @(posedge clk);
    cfg_index <= scrs_pkg::REG_HOLD_TIME;
    cfg_wdata <= s.hold_time;
    @(posedge clk);
    cfg_index <= scrs_pkg::REG_RELEASE_THRESHOLD;
    cfg_wdata <= s.release_threshold;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.settings = s;
    settings_applied++;
  endtask

  task automatic reconfigure(input scrs_pkg::cfg_t s);
    drain();
    apply_settings(s);
  endtask

  // result side: check accepted items, then pick the stall for the next cycle
  initial begin : result_side
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_command(out_send_strobe, out_color_code, out_phase, out_retries_left);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_request > 0) begin
        // long hold-off so the block backs up into its input
        hold_left = hold_request - 1;
        hold_request = 0;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // hang detection
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    scrs_pkg::cfg_t s;
    logic [4:0] held;
    int         ack_pct;
    int         nak_pct;
    int         r;
    sb = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_switch_levels <= '0;
    in_ack_ok <= 1'b0;
    in_ack_nok <= 1'b0;
    in_tick <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= scrs_pkg::REG_RETRY_LIMIT;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: flags ignored in idle, cold over everything, nak, ack with nak
    offer_pass(5'h00, 1'b1, 1'b1, 1'b1);
    offer_pass(5'h1f, 1'b0, 1'b0, 1'b0);
    offer_pass(5'h1f, 1'b0, 1'b0, 1'b0);
    offer_pass(5'h00, 1'b0, 1'b1, 1'b0);
    offer_pass(5'h00, 1'b0, 1'b0, 1'b1);
    offer_pass(5'h00, 1'b1, 1'b1, 1'b0);
    offer_pass(5'h00, 1'b0, 1'b0, 1'b0);
    offer_pass(5'h00, 1'b1, 1'b0, 1'b1);

    // top of every range: release below threshold, held switch keeps wait release
    reconfigure('{4'd15, 16'hffff, 16'hffff, 16'hffff});
    offer_pass(5'h00, 1'b0, 1'b0, 1'b1);
    offer_pass(5'h08, 1'b0, 1'b0, 1'b0);
    offer_pass(5'h08, 1'b0, 1'b0, 1'b0);
    offer_pass(5'h08, 1'b0, 1'b0, 1'b1);
    offer_pass(5'h08, 1'b1, 1'b0, 1'b0);
    offer_pass(5'h02, 1'b0, 1'b0, 1'b1);
    offer_pass(5'h00, 1'b0, 1'b0, 1'b0);

    // zero retry limit: send finds no attempts and drops back without a strobe
    reconfigure('{4'd0, 16'd0, 16'd0, 16'd0});
    offer_pass(5'h04, 1'b0, 1'b0, 1'b0);
    offer_pass(5'h04, 1'b0, 1'b0, 1'b0);

    // zero ack timeout retries at once, zero hold time resends after an ack
    reconfigure('{4'd2, 16'd0, 16'd0, 16'd0});
    offer_pass(5'h02, 1'b0, 1'b0, 1'b0);
    offer_pass(5'h00, 1'b0, 1'b0, 1'b0);
    offer_pass(5'h00, 1'b0, 1'b0, 1'b1);
    offer_pass(5'h00, 1'b0, 1'b0, 1'b0);
    offer_pass(5'h00, 1'b1, 1'b0, 1'b0);
    offer_pass(5'h00, 1'b0, 1'b0, 1'b0);
    offer_pass(5'h01, 1'b0, 1'b0, 1'b0);

    // random phases, each with its own settings and idle pattern
    held = '0;
    for (int k = 0; k < RANDOM_PHASES; k++) begin
      if (k == 3) begin
        s = '{4'd15, 16'd1, 16'd1, 16'd0};
      end else if (k == 6) begin
        s = '{4'd15, 16'hffff, 16'hffff, 16'hffff};
      end else begin
        // short timers so timeouts and expiries happen often
        s.retry_limit = 4'($urandom_range(15));
        s.ack_timeout = 16'($urandom_range(12, 1));
        s.hold_time = 16'($urandom_range(30, 1));
        s.release_threshold = 16'($urandom_range(35));
      end
      reconfigure(s);
      case (k % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 72; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 72; end
        default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase
      ack_pct = $urandom_range(25, 3);
      nak_pct = $urandom_range(15);
      if (k == 4) hold_request = HOLD_OFF_CYCLES;
      for (int n = 0; n < PASSES_PER_PHASE; n++) begin
        // switches mostly stay put, with occasional release or new press
        r = $urandom_range(99);
        if (r < 4) held = '0;
        else if (r < 10) held = 5'($urandom_range(31));
        if ($urandom_range(99) < 12)
          offer_pass(5'($urandom_range(31)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
        else
          offer_pass(held, $urandom_range(99) < ack_pct, $urandom_range(99) < nak_pct,
                     1'($urandom_range(1)));
      end
    end

    drain();
    $display("covered %0d control passes under %0d register settings", sb.accepted,
             settings_applied);
    $display("checked %0d result items, %0d of them with a send strobe", sb.checked,
             sb.strobes);
    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- switch_command_retry_sender.f -----
+incdir+src
src/scrs_pkg.sv
src/scrs_cfg.sv
src/scrs_step.sv
src/switch_command_retry_sender.sv
bench/tb_switch_command_retry_sender.sv
